### hdl/tps_pkg.sv
// Package: constants, opcodes and types of the temperature profile sequencer.
package tps_pkg;

  localparam int MaxStepsDef    = 16;
  localparam int SampleEveryDef = 4;
  localparam logic [3:0] ForceSample = 4'd11;
  localparam int SecPerMin = 60;

  typedef enum logic [3:0] {
    OP_TICK   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_START  = 4'd2,
    OP_PAUSE  = 4'd3,
    OP_RESUME = 4'd4,
    OP_SKIP   = 4'd5,
    OP_TARGET = 4'd6,
    OP_PUMP   = 4'd7,
    OP_MUTE   = 4'd8,
    OP_ACK    = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ZERO   = 3'd0,
    REG_GAIN   = 3'd1,
    REG_OFFSET = 3'd2,
    REG_HON    = 3'd3,
    REG_HOFF   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic signed [15:0] raw_sample;
    logic [3:0]  load_index;
    logic [10:0] load_temp;
    logic [7:0]  load_minutes;
    logic        load_hold;
    logic [4:0]  program_length;
    logic [10:0] manual_target;
  } in_word_t;

  typedef struct packed {
    logic        heater_on;
    logic        pump_on;
    logic        alarm_on;
    logic        auto_running;
    logic        waiting_temp;
    logic        holding;
    logic [4:0]  current_step;
    logic [13:0] seconds_left;
    logic signed [15:0] measured_temp;
    logic [10:0] target_temp;
    logic        profile_done;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_word_t;

endpackage

### hdl/tps_if.sv
// Interfaces: valid/ready channels for input, result and configuration words.
interface tps_in_if;
  logic valid;
  logic ready;
  tps_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tps_out_if;
  logic valid;
  logic ready;
  tps_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tps_cfg_if;
  logic valid;
  logic ready;
  tps_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/tps_ram.sv
// Generic single-port-write RAM with registered read.
module tps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/temperature_profile_sequencer.sv
// Top level: heater profile sequencer with step RAM and serial calibration divider.
//
//  channel | dir | word        | accepted when
//  in_     | in  | in_word_t   | in_valid & in_ready
//  out_    | out | out_word_t  | out_valid & out_ready
//  cfg_    | in  | cfg_word_t  | cfg_valid & cfg_ready
//
// Non-sampling items: a step RAM read and capture in READ, EXEC to apply, then the
// result word in OUT.
// A sampling tick adds the DIV state for the restoring divider, 1 bit per cycle.
// One item at a time; in_ready is low from accept until the result is taken.
// A stalled output holds the result word and the block.
// rst_n is synchronous; the step RAM has no reset and needs no clearing pass.
module temperature_profile_sequencer
  import tps_pkg::*;
#(
  parameter int MaxSteps    = tps_pkg::MaxStepsDef,
  parameter int SampleEvery = tps_pkg::SampleEveryDef
) (
  input logic clk,
  input logic rst_n,
  tps_in_if.sink    in_ch,
  tps_out_if.source out_ch,
  tps_cfg_if.sink   cfg_ch
);
  localparam int AW = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int DW = 34;
  localparam logic [6:0] MSW = 7'(MaxSteps);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_EXEC = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  in_word_t item_r;

  // Configuration registers
  logic signed [15:0] zero_r;
  logic [15:0] gain_r;
  logic signed [10:0] offs_r;
  logic [7:0] hon_r, hoff_r;

  // Control state
  logic [4:0]  total_r, step_r;
  logic [13:0] cnt_r, saved_r;
  logic [3:0]  div_r;
  logic wait_r, auto_r, heat_r, pump_r, alarm_r, hold_r, done_r;
  logic [10:0] tgt_r;
  logic signed [15:0] temp_r;

  // Step memory: {temp, minutes, hold}
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [19:0] ram_wdata, ram_rdata;

  tps_ram #(.Width(20), .Depth(2**AW)) u_steps (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Divider
  logic [DW-1:0] dq_r, rem_r;
  logic [5:0]    dcnt_r;
  logic          neg_r;
  logic [DW:0]   rem_sh;
  logic [15:0]   gain_eff;

  assign gain_eff = (gain_r == 16'd0) ? 16'd1 : gain_r;
  assign rem_sh = {rem_r, dq_r[DW-1]};

  // Step index to read: next step on ACK; start reads entry 0; otherwise the current step
  logic [4:0] nstep;
  logic [4:0] rd_idx;
  assign nstep = step_r + 5'd1;
  always_comb begin
    rd_idx = step_r;
    if (item_r.opcode == OP_START) rd_idx = '0;
    else if (item_r.opcode == OP_ACK) rd_idx = nstep;
    else if (item_r.opcode == OP_TICK && !hold_r && cnt_r == 14'd0 && !wait_r)
      rd_idx = step_r;
  end
  assign ram_raddr = AW'(rd_idx);
  assign ram_we = (state_r == ST_IDLE) && in_ch.valid && in_ch.ready &&
                  (in_ch.data.opcode == OP_LOAD) &&
                  ({3'b000, in_ch.data.load_index} < MSW);
  assign ram_waddr = AW'(in_ch.data.load_index);
  assign ram_wdata = {in_ch.data.load_temp, in_ch.data.load_minutes,
                      in_ch.data.load_hold};

  // Held entries: current step captured in READ; next step from the second memory view
  logic [19:0] ent_r, nent_r;
  logic        ent_ok_r, nent_ok_r;
  logic        fetch2_r;

  logic sampling;
  assign sampling = (item_r.opcode == OP_TICK) &&
                    (div_r == ForceSample || (5'(div_r) + 5'd1) >= 5'(SampleEvery));

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_OUT);

  // Signed calibrated temperature after divide
  logic signed [35:0] tq;
  logic signed [15:0] tsat;
  always_comb begin
    tq = neg_r ? -$signed({2'b00, dq_r}) : $signed({2'b00, dq_r});
    tq = tq + 36'(offs_r);
    if (tq > 36'sd32767) tsat = 16'sh7fff;
    else if (tq < -36'sd32768) tsat = 16'sh8000;
    else tsat = tq[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_READ;
      ST_READ: if (!fetch2_r) state_nxt = ST_READ;
               else state_nxt = sampling ? ST_DIV : ST_EXEC;
      ST_DIV:  if (dcnt_r == 6'd0) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= '0; gain_r <= 16'd256; offs_r <= '0; hon_r <= 8'd5; hoff_r <= 8'd5;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.data.index))
        REG_ZERO:   zero_r <= cfg_ch.data.data;
        REG_GAIN:   gain_r <= cfg_ch.data.data;
        REG_OFFSET: offs_r <= cfg_ch.data.data[10:0];
        REG_HON:    hon_r  <= cfg_ch.data.data[7:0];
        REG_HOFF:   hoff_r <= cfg_ch.data.data[7:0];
        default: ;
      endcase
    end
  end

  // Main sequencing
  logic signed [17:0] diff;
  assign diff = 18'(item_r.raw_sample) - 18'(zero_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0; step_r <= '0; cnt_r <= '0; saved_r <= '0; div_r <= ForceSample;
      wait_r <= 1'b1; auto_r <= 1'b0; heat_r <= 1'b0; pump_r <= 1'b0;
      alarm_r <= 1'b0; hold_r <= 1'b0; done_r <= 1'b0; tgt_r <= '0; temp_r <= '0;
      fetch2_r <= 1'b0; dcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          fetch2_r <= 1'b0;
          if (in_ch.valid) item_r <= in_ch.data;
        end
        ST_READ: begin
          // fetch2_r low: RAM read of rd_idx issued; fetch2_r high: capture
          fetch2_r <= 1'b1;
          if (fetch2_r) begin
            ent_r <= ram_rdata;
            ent_ok_r <= {2'b00, rd_idx} < MSW;
            if (sampling) begin
              neg_r <= diff[17];
              dq_r  <= 34'(diff[17] ? -diff : diff) * 34'd2560
                       + 34'(gain_eff >> 1);
              rem_r <= '0;
              dcnt_r <= 6'(DW);
            end
          end
        end
        ST_DIV: begin
          // one restoring-division bit per cycle
          if (dcnt_r != 6'd0) begin
            if (rem_sh >= {19'd0, gain_eff}) begin
              rem_r <= DW'(rem_sh - {19'd0, gain_eff});
              dq_r  <= {dq_r[DW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh[DW-1:0];
              dq_r  <= {dq_r[DW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 6'd1;
          end
        end
        ST_EXEC: exec_item();
        default: ;
      endcase
    end
  end

  // Apply the item; uses a task with no timing for readability
  logic [13:0] ent_time;
  logic [10:0] ent_temp;
  logic        ent_hold;
  assign ent_temp = ent_ok_r ? ent_r[19:9] : 11'd0;
  assign ent_time = ent_ok_r ? 14'(ent_r[8:1] * 14'(SecPerMin)) : 14'd0;
  assign ent_hold = ent_ok_r ? ent_r[0] : 1'b0;

  // Next entry register: read from the second memory view in every state using raddr of next step
  logic [10:0] nent_temp;
  logic [13:0] nent_time;
  assign nent_temp = nent_ok_r ? nent_r[19:9] : 11'd0;
  assign nent_time = nent_ok_r ? 14'(nent_r[8:1] * 14'(SecPerMin)) : 14'd0;

  task automatic exec_item();
    logic signed [17:0] t18, tg;
    logic signed [17:0] hon_s, hoff_s;
    logic [4:0] n;
    logic adv;
    logic a;
    logic [13:0] c;
    logic [4:0] s;
    logic [10:0] g;
    logic w;
    logic [3:0] dv;
    logic h;
    logic hh;
    logic dn;
    t18 = 18'(tsat);
    tg = 18'(tgt_r);
    hon_s = 18'(hon_r);
    hoff_s = 18'(hoff_r);
    n = '0; adv = 1'b0;
    a = auto_r; c = cnt_r; s = step_r; g = tgt_r; w = wait_r; dv = div_r; h = hold_r;
    hh = heat_r; dn = 1'b0;
    case (opcode_t'(item_r.opcode))
      OP_TICK: begin
        if (!w && c != 14'd0) c = c - 14'd1;
        if (sampling) begin
          dv = '0;
          temp_r <= tsat;
          if (t18 - hon_s < tg) begin hh = 1'b1; pump_r <= 1'b1; end
          if (t18 + hoff_s > tg) hh = 1'b0;
          if (a && !h) begin
            if (w) begin
              if (t18 >= tg - hoff_s) w = 1'b0;
              if (s < total_r) g = ent_temp;
            end else if (c == 14'd0) begin
              alarm_r <= 1'b1;
              if (ent_hold) h = 1'b1;
              else adv = 1'b1;
            end else if (s < total_r) g = ent_temp;
          end
        end else begin
          dv = 4'(dv + 4'd1);
        end
      end
      OP_LOAD: ;
      OP_START: begin
        n = ({2'b00, item_r.program_length} > MSW) ? 5'(MaxSteps) : item_r.program_length;
        if (item_r.program_length != 5'd0) begin
          total_r <= n; a = 1'b1; s = '0; w = 1'b1; pump_r <= 1'b1; h = 1'b0;
          g = ent_temp; c = ent_time;
        end
      end
      OP_PAUSE: if (a && !h) begin a = 1'b0; saved_r <= c; c = '0; end
      OP_RESUME: if (!a && s < total_r) begin a = 1'b1; c = saved_r; end
      OP_SKIP: if (a && !h) begin c = '0; g = '0; end
      OP_TARGET: g = item_r.manual_target;
      OP_PUMP: pump_r <= !pump_r;
      OP_MUTE: alarm_r <= 1'b0;
      OP_ACK: if (h) begin alarm_r <= 1'b0; h = 1'b0; adv = 1'b1; end
      default: ;
    endcase
    if (item_r.opcode != OP_TICK) dv = ForceSample;
    if (adv) begin
      // advance needs next entry; read from the second memory view
      s = s + 5'd1;
      if (s >= total_r) begin
        a = 1'b0; g = '0; dn = 1'b1;
      end else begin
        c = nent_time; g = nent_temp; dv = ForceSample; w = 1'b1;
      end
    end
    auto_r <= a; cnt_r <= c; step_r <= s; tgt_r <= g; wait_r <= w;
    div_r <= dv; hold_r <= h; heat_r <= hh; done_r <= dn;
  endtask

  // Second memory view holds the following step for advance
  tps_ram #(.Width(20), .Depth(2**AW)) u_next (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(AW'(nstep)), .rdata(nent_r)
  );
  always_ff @(posedge clk) begin
    nent_ok_r <= {2'b00, nstep} < MSW;
  end

  assign out_ch.data = '{heater_on: heat_r, pump_on: pump_r, alarm_on: alarm_r,
                         auto_running: auto_r, waiting_temp: wait_r, holding: hold_r,
                         current_step: step_r, seconds_left: cnt_r,
                         measured_temp: temp_r, target_temp: tgt_r,
                         profile_done: done_r};
endmodule

### hdl/tps_checker.sv
// Checker: port-level assertions on the sequencer, bound to the top level.
module tps_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_done,
  input logic out_auto
);
  // no new word while a result waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // accepted word closes the input
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("input not closed");
  // done implies automatic mode ended
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done) |-> !out_auto) else $error("done while running");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind temperature_profile_sequencer tps_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_done(out_ch.data.profile_done), .out_auto(out_ch.data.auto_running)
);
